// ----- rtl/core/pcte_pkg.sv -----
// shared types, constants and register codes of the timing event scheduler
package pcte_pkg;

   localparam int LINES_PER_FRAME = 525;
   localparam int VISIBLE_LINES   = 480;
   localparam int PIT_CHANNELS    = 3;

   localparam int LINE_W    = $clog2(LINES_PER_FRAME);
   localparam int TIME_W    = 64;
   localparam int PERIOD_W  = 32;
   localparam int COUNT_W   = 16;
   localparam int SCANLINE_W = 10;
   localparam int AUDIO_W   = 3;
   localparam int STATUS_W  = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [COUNT_W-1:0]  PIT_STEP        = COUNT_W'(10);
   localparam logic [PERIOD_W-1:0] SAMPLE_DISABLED = '1;
   localparam logic [AUDIO_W-1:0]  AUDIO_ONE       = AUDIO_W'(1);
   localparam logic [AUDIO_W-1:0]  AUDIO_FOUR      = AUDIO_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCANLINE_PERIOD = 3'd0,
      REG_IRQ_PERIOD      = 3'd1,
      REG_PIT_PERIOD      = 3'd2,
      REG_SOURCE_PERIOD   = 3'd3,
      REG_BLASTER_PERIOD  = 3'd4,
      REG_SAMPLE_PERIOD   = 3'd5,
      REG_ADLIB_PERIOD    = 3'd6,
      REG_SLOW_SYSTEM     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] scanline_period;
      logic [PERIOD_W-1:0] irq_period;
      logic [PERIOD_W-1:0] pit_period;
      logic [PERIOD_W-1:0] source_period;
      logic [PERIOD_W-1:0] blaster_period;
      logic [PERIOD_W-1:0] sample_period;
      logic [PERIOD_W-1:0] adlib_period;
      logic                slow_system;
   } cfg_type;

   // packed msb first, so the first field sits in the highest bits
   typedef struct packed {
      logic [COUNT_W-1:0] pit_reload_2;
      logic [COUNT_W-1:0] pit_reload_1;
      logic [COUNT_W-1:0] pit_reload_0;
      logic [2:0]         pit_active;
      logic [TIME_W-1:0]  now;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    pit_count_2;
      logic [COUNT_W-1:0]    pit_count_1;
      logic [COUNT_W-1:0]    pit_count_0;
      logic [SCANLINE_W-1:0] scanline;
      logic [STATUS_W-1:0]   status_3da;
      logic                  adlib_tick;
      logic [AUDIO_W-1:0]    audio_ticks;
      logic                  blaster_tick;
      logic                  source_tick;
      logic                  irq_fire;
   } rsp_type;

   localparam int REQ_W      = $bits(req_type);
   localparam int RSP_W      = $bits(rsp_type);
   localparam int REQ_DATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

// ----- rtl/core/pcte_csr.sv -----
// configuration registers of the timing event scheduler
module pcte_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wen,
   input  logic [pcte_pkg::CSR_IDX_W-1:0] index,
   input  logic [pcte_pkg::PERIOD_W-1:0]  wdata,
   output pcte_pkg::cfg_type              cfg
);
   import pcte_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wen) begin
         unique case (reg_index_type'(index))
            REG_SCANLINE_PERIOD: cfg_in.scanline_period = wdata;
            REG_IRQ_PERIOD:      cfg_in.irq_period      = wdata;
            REG_PIT_PERIOD:      cfg_in.pit_period      = wdata;
            REG_SOURCE_PERIOD:   cfg_in.source_period   = wdata;
            REG_BLASTER_PERIOD:  cfg_in.blaster_period  = wdata;
            REG_SAMPLE_PERIOD:   cfg_in.sample_period   = wdata;
            REG_ADLIB_PERIOD:    cfg_in.adlib_period    = wdata;
            REG_SLOW_SYSTEM:     cfg_in.slow_system     = wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scanline_period <= PERIOD_W'(31);
         cfg_ff.irq_period      <= PERIOD_W'(54925);
         cfg_ff.pit_period      <= PERIOD_W'(8);
         cfg_ff.source_period   <= PERIOD_W'(125);
         cfg_ff.blaster_period  <= '0;
         cfg_ff.sample_period   <= SAMPLE_DISABLED;
         cfg_ff.adlib_period    <= PERIOD_W'(20);
         cfg_ff.slow_system     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/pcte_due.sv -----
// deadline compare: due when now reaches mark plus period, sum taken without wrap
module pcte_due (
   input  logic [pcte_pkg::TIME_W-1:0]   now,
   input  logic [pcte_pkg::TIME_W-1:0]   mark,
   input  logic [pcte_pkg::PERIOD_W-1:0] period,
   output logic                          due,
   output logic [pcte_pkg::TIME_W-1:0]   deadline
);
   import pcte_pkg::*;

   logic [TIME_W:0] sum;

   assign sum      = {1'b0, mark} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period};
   assign deadline = sum[TIME_W-1:0];
   // a deadline beyond the end of time is never reached
   assign due      = !sum[TIME_W] && (now >= sum[TIME_W-1:0]);

endmodule

// ----- rtl/core/pcte_core.sv -----
// event state: deadline marks, scanline counter and timer channel counts
module pcte_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  pcte_pkg::req_type item,
   input  pcte_pkg::cfg_type cfg,
   output pcte_pkg::rsp_type result
);
   import pcte_pkg::*;

   logic [TIME_W-1:0] line_mark_ff,    line_mark_in;
   logic [TIME_W-1:0] irq_mark_ff,     irq_mark_in;
   logic [TIME_W-1:0] pit_mark_ff,     pit_mark_in;
   logic [TIME_W-1:0] source_mark_ff,  source_mark_in;
   logic [TIME_W-1:0] blaster_mark_ff, blaster_mark_in;
   logic [TIME_W-1:0] audio_mark_ff,   audio_mark_in;
   logic [TIME_W-1:0] adlib_mark_ff,   adlib_mark_in;
   logic [LINE_W-1:0] line_ff,         line_in;
   logic [COUNT_W-1:0] count_ff [PIT_CHANNELS];
   logic [COUNT_W-1:0] count_in [PIT_CHANNELS];

   logic line_due, irq_due, pit_due, source_due, blaster_due, audio_due, adlib_due;
   logic [TIME_W-1:0] line_dl, irq_dl, pit_dl, source_dl, blaster_dl, audio_dl, adlib_dl;

   logic               irq_fire, blaster_fire, audio_fire;
   logic [LINE_W-1:0]  line_wrap;
   logic [COUNT_W-1:0] reload [3];
   logic [COUNT_W-1:0] count_out [3];

   pcte_due u_line_due (.now(item.now), .mark(line_mark_ff), .period(cfg.scanline_period),
                        .due(line_due), .deadline(line_dl));
   pcte_due u_irq_due (.now(item.now), .mark(irq_mark_ff), .period(cfg.irq_period),
                       .due(irq_due), .deadline(irq_dl));
   pcte_due u_pit_due (.now(item.now), .mark(pit_mark_ff), .period(cfg.pit_period),
                       .due(pit_due), .deadline(pit_dl));
   pcte_due u_source_due (.now(item.now), .mark(source_mark_ff), .period(cfg.source_period),
                          .due(source_due), .deadline(source_dl));
   pcte_due u_blaster_due (.now(item.now), .mark(blaster_mark_ff),
                           .period(cfg.blaster_period), .due(blaster_due),
                           .deadline(blaster_dl));
   pcte_due u_audio_due (.now(item.now), .mark(audio_mark_ff), .period(cfg.sample_period),
                         .due(audio_due), .deadline(audio_dl));
   pcte_due u_adlib_due (.now(item.now), .mark(adlib_mark_ff), .period(cfg.adlib_period),
                         .due(adlib_due), .deadline(adlib_dl));

   assign irq_fire     = item.pit_active[0] && irq_due;
   assign blaster_fire = (cfg.blaster_period != '0) && blaster_due;
   assign audio_fire   = (cfg.sample_period != SAMPLE_DISABLED) && audio_due;

   assign line_wrap = (line_ff == LINE_W'(LINES_PER_FRAME - 1)) ? '0 : line_ff + 1'b1;

   always_comb begin
      // restarting sources take now, catching-up sources move one period
      line_mark_in    = line_due     ? item.now   : line_mark_ff;
      irq_mark_in     = irq_fire     ? item.now   : irq_mark_ff;
      pit_mark_in     = pit_due      ? item.now   : pit_mark_ff;
      source_mark_in  = source_due   ? source_dl  : source_mark_ff;
      blaster_mark_in = blaster_fire ? blaster_dl : blaster_mark_ff;
      audio_mark_in   = audio_fire   ? audio_dl   : audio_mark_ff;
      adlib_mark_in   = adlib_due    ? adlib_dl   : adlib_mark_ff;
      line_in         = line_due     ? line_wrap  : line_ff;
   end

   assign reload[0] = item.pit_reload_0;
   assign reload[1] = item.pit_reload_1;
   assign reload[2] = item.pit_reload_2;

   for (genvar ch = 0; ch < 3; ch++) begin : g_pit
      if (ch < PIT_CHANNELS) begin : g_used
         logic [COUNT_W-1:0] base;
         assign base = (count_ff[ch] < PIT_STEP) ? reload[ch] : count_ff[ch];
         assign count_in[ch]  = (pit_due && item.pit_active[ch]) ? base - PIT_STEP
                                                                 : count_ff[ch];
         assign count_out[ch] = count_in[ch];
      end else begin : g_unused
         assign count_out[ch] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_mark_ff    <= '0;
         irq_mark_ff     <= '0;
         pit_mark_ff     <= '0;
         source_mark_ff  <= '0;
         blaster_mark_ff <= '0;
         audio_mark_ff   <= '0;
         adlib_mark_ff   <= '0;
         line_ff         <= '0;
         for (int ch = 0; ch < PIT_CHANNELS; ch++) begin
            count_ff[ch] <= '0;
         end
      end else if (step) begin
         line_mark_ff    <= line_mark_in;
         irq_mark_ff     <= irq_mark_in;
         pit_mark_ff     <= pit_mark_in;
         source_mark_ff  <= source_mark_in;
         blaster_mark_ff <= blaster_mark_in;
         audio_mark_ff   <= audio_mark_in;
         adlib_mark_ff   <= adlib_mark_in;
         line_ff         <= line_in;
         for (int ch = 0; ch < PIT_CHANNELS; ch++) begin
            count_ff[ch] <= count_in[ch];
         end
      end
   end

   always_comb begin
      result              = '0;
      result.irq_fire     = irq_fire;
      result.source_tick  = source_due;
      result.blaster_tick = blaster_fire;
      result.audio_ticks  = audio_fire ? (cfg.slow_system ? AUDIO_FOUR : AUDIO_ONE) : '0;
      result.adlib_tick   = adlib_due;
      result.scanline     = SCANLINE_W'(line_in);
      // retrace below the visible area, bit 0 follows odd lines
      result.status_3da   = {({1'b0, line_in} >= (LINE_W + 1)'(VISIBLE_LINES)), 2'b00,
                             line_in[0]};
      result.pit_count_0  = count_out[0];
      result.pit_count_1  = count_out[1];
      result.pit_count_2  = count_out[2];
   end

   a_line_moves: assert property (@(posedge clock) disable iff (reset)
      (step && line_due) |=> (line_ff != $past(line_ff)))
      else $error("scanline did not advance on a due scanline event");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(line_ff) && $stable(irq_mark_ff) && $stable(audio_mark_ff)))
      else $error("event state changed without a step");

endmodule

// ----- rtl/core/pc_timing_event_scheduler.sv -----
// top level of the timing event scheduler: stream ports, input and result registers
// path: a request goes into the input register, then its result into the result register;
//   the event logic is combinational between the two registers
// throughput: one transaction per cycle while rsp_tready is high; rsp_tready low holds
//   the result register, and the input register still takes one more request if empty
// reset: synchronous, active high; clears marks, scanline, timer counts and valids,
//   and loads the configuration register defaults
module pc_timing_event_scheduler (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // now[63:0], pit_active[66:64], pit_reload_0[82:67], pit_reload_1[98:83],
   // pit_reload_2[114:99], zero fill above
   input  logic [119:0] req_tdata,
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // irq_fire[0], source_tick[1], blaster_tick[2], audio_ticks[5:3], adlib_tick[6],
   // status_3da[10:7], scanline[20:11], pit_count_0[36:21], pit_count_1[52:37],
   // pit_count_2[68:53], zero fill above
   output logic [71:0]  rsp_tdata,
   // configuration write port
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import pcte_pkg::*;

   cfg_type cfg;
   rsp_type result;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic advance;
   logic step;

   pcte_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wen   (csr_wen),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   pcte_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register frees up when empty or being drained this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   // the held request is processed as it moves into the result register
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_type'(req_tdata[REQ_W-1:0]);
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_W){1'b0}}, out_data_ff};

   a_scanline_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, out_data_ff.scanline} < (SCANLINE_W + 1)'(LINES_PER_FRAME)))
      else $error("scanline out of frame range");

   a_status_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_data_ff.status_3da[0] == out_data_ff.scanline[0]) &&
                      (out_data_ff.status_3da[3] ==
                       ({1'b0, out_data_ff.scanline} >= (SCANLINE_W + 1)'(VISIBLE_LINES)))))
      else $error("status bits disagree with scanline");

   a_audio_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_data_ff.audio_ticks == '0) ||
                      (out_data_ff.audio_ticks == AUDIO_ONE) ||
                      (out_data_ff.audio_ticks == AUDIO_FOUR)))
      else $error("illegal audio tick count");

endmodule
